FILE: design/sdtq_pkg.sv
// shared types and constants of the sorted deadline timer queue
package sdtq_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_ADJUST = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_EXPIRED   = 3'd1;
    localparam logic [2:0] ST_NONE      = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_DUP       = 3'd5;

    localparam int MAX_REPORTS = 32;
    localparam int RPT_W       = 6;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] handle;
        logic [47:0] deadline;
        logic [47:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] expired_handle;
        logic [47:0] expired_time;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [15:0] handle;
        logic [47:0] expiry;
    } entry_t;

endpackage

FILE: design/sdtq_store.sv
// entry memory with one write port and one registered read port
module sdtq_store
    import sdtq_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem_reg [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/sdtq_ctrl.sv
// sequencer that scans, shifts and pops the circular sorted entry list
module sdtq_ctrl
    import sdtq_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int AW       = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  in_item_t      in_item,
    output logic          res_valid,
    output out_item_t     res_item,
    input  logic          res_ready,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output entry_t        mem_wdata,
    output logic [AW-1:0] mem_raddr,
    input  entry_t        mem_rdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_FIND_RD  = 8'b0000_0010,
        S_FIND_CHK = 8'b0000_0100,
        S_INS_RD   = 8'b0000_1000,
        S_INS_CHK  = 8'b0001_0000,
        S_TICK_RD  = 8'b0010_0000,
        S_TICK_CHK = 8'b0100_0000,
        S_RESP     = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    in_item_t         item_reg, item_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic             found_reg, found_next;
    logic             placed_reg, placed_next;
    logic             hold_valid_reg, hold_valid_next;
    entry_t           held_reg, held_next;
    logic [RPT_W-1:0] rpt_reg, rpt_next;
    logic [2:0]       status_reg, status_next;

    logic at_end;
    logic due;

    function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] head,
                                                 input logic [CW-1:0] lidx);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(lidx);
        if (sum >= SW'(CAPACITY)) begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    assign in_ready = (state_reg == S_IDLE);
    assign at_end   = (idx_reg == count_reg);
    assign due      = (count_reg != '0) && (mem_rdata.expiry <= item_reg.now_time)
                      && (rpt_reg < RPT_W'(MAX_REPORTS));

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        placed_next     = placed_reg;
        hold_valid_next = hold_valid_reg;
        held_next       = held_reg;
        rpt_next        = rpt_reg;
        status_next     = status_reg;
        mem_we          = 1'b0;
        mem_waddr       = wrap_addr(head_reg, idx_reg);
        mem_wdata       = held_reg;
        mem_raddr       = wrap_addr(head_reg, idx_reg);
        res_valid       = 1'b0;
        res_item        = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    item_next       = in_item;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    placed_next     = 1'b0;
                    hold_valid_next = 1'b0;
                    rpt_next        = '0;
                    state_next      = (in_item.op == OP_TICK) ? S_TICK_RD : S_FIND_RD;
                end
            end
            S_FIND_RD: begin
                if (!at_end) begin
                    state_next = S_FIND_CHK;
                end else if (item_reg.op == OP_ADD) begin
                    if (count_reg == CW'(CAPACITY)) begin
                        status_next = ST_FULL;
                        state_next  = S_RESP;
                    end else begin
                        idx_next   = '0;
                        state_next = S_INS_RD;
                    end
                end else if (!found_reg) begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_RESP;
                end else begin
                    count_next = count_reg - CW'(1);
                    if (item_reg.op == OP_ADJUST) begin
                        idx_next   = '0;
                        state_next = S_INS_RD;
                    end else begin
                        status_next = ST_DONE;
                        state_next  = S_RESP;
                    end
                end
            end
            S_FIND_CHK: begin
                idx_next   = idx_reg + CW'(1);
                state_next = S_FIND_RD;
                if (found_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = wrap_addr(head_reg, idx_reg - CW'(1));
                    mem_wdata = mem_rdata;
                end else if (mem_rdata.handle == item_reg.handle) begin
                    if (item_reg.op == OP_ADD) begin
                        status_next = ST_DUP;
                        state_next  = S_RESP;
                    end else begin
                        found_next = 1'b1;
                    end
                end
            end
            S_INS_RD: begin
                state_next = S_INS_CHK;
            end
            S_INS_CHK: begin
                if (!placed_reg) begin
                    if (at_end || (mem_rdata.expiry > item_reg.deadline)) begin
                        mem_we      = 1'b1;
                        mem_wdata   = '{handle: item_reg.handle,
                                        expiry: item_reg.deadline};
                        held_next   = mem_rdata;
                        placed_next = 1'b1;
                    end
                end else begin
                    mem_we    = 1'b1;
                    held_next = mem_rdata;
                end
                if (at_end) begin
                    count_next  = count_reg + CW'(1);
                    status_next = ST_DONE;
                    state_next  = S_RESP;
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_INS_RD;
                end
            end
            S_TICK_RD: begin
                state_next = S_TICK_CHK;
            end
            S_TICK_CHK: begin
                if (due) begin
                    if (!hold_valid_reg || res_ready) begin
                        if (hold_valid_reg) begin
                            res_valid = 1'b1;
                            res_item  = '{status: ST_EXPIRED,
                                          expired_handle: held_reg.handle,
                                          expired_time: held_reg.expiry,
                                          last: 1'b0};
                        end
                        held_next       = mem_rdata;
                        hold_valid_next = 1'b1;
                        head_next       = wrap_addr(head_reg, CW'(1));
                        count_next      = count_reg - CW'(1);
                        rpt_next        = rpt_reg + RPT_W'(1);
                        state_next      = S_TICK_RD;
                    end
                end else if (res_ready) begin
                    res_valid = 1'b1;
                    if (hold_valid_reg) begin
                        res_item = '{status: ST_EXPIRED,
                                     expired_handle: held_reg.handle,
                                     expired_time: held_reg.expiry,
                                     last: 1'b1};
                    end else begin
                        res_item = '{status: ST_NONE, expired_handle: '0,
                                     expired_time: '0, last: 1'b1};
                    end
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            S_RESP: begin
                if (res_ready) begin
                    res_valid  = 1'b1;
                    res_item   = '{status: status_reg, expired_handle: '0,
                                   expired_time: '0, last: 1'b1};
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            head_reg       <= '0;
            hold_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            hold_valid_reg <= hold_valid_next;
        end
        item_reg   <= item_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        placed_reg <= placed_next;
        held_reg   <= held_next;
        rpt_reg    <= rpt_next;
        status_reg <= status_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_FIND_CHK || state_reg == S_INS_CHK))
        else $error("memory write outside a shift step");

    a_result_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> res_ready)
        else $error("result issued without room in the output register");

    a_idle_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !hold_valid_reg)
        else $error("pending expired entry left behind");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("transfer accepted but sequencer stayed idle");
`endif

endmodule

FILE: design/sorted_deadline_timer_queue.sv
// top level of the sorted deadline timer queue
// usage:
//   s_item carries op, handle, deadline and now_time; an op is taken on a
//   transfer with s_valid and s_ready high. s_ready is high only while the
//   sequencer is idle, so one op is processed at a time.
//   m_item carries status, expired_handle, expired_time and last; add,
//   adjust and delete give one result each, a tick one result per expired
//   entry (up to 32) or a single nothing-expired result, with last set on
//   the final one.
//   ops step through the stored entries one at a time, each read through
//   the registered read port of the entry memory.
//   entries live in a circular buffer, so a tick pops the head in place.
//   reset empties the queue at once; the entry memory itself is not cleared.
//   results sit in an output register; while it is full and m_ready is low
//   the sequencer waits before issuing the next result, and s_ready stays
//   low meanwhile only if the current op is not finished.
module sorted_deadline_timer_queue
    import sdtq_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int AW = $clog2(CAPACITY);

    logic          res_valid;
    out_item_t     res_item;
    logic          res_ready;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [AW-1:0] mem_raddr;
    entry_t        mem_rdata;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_item_reg, m_item_next;

    sdtq_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_item),
        .res_valid (res_valid),
        .res_item  (res_item),
        .res_ready (res_ready),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    sdtq_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_item_next  = res_item;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
